FILE: rtl/tdmsa_pkg.sv
// ----------------------------------------------------------------------------
// tdmsa_pkg
// Shared types, constants and helpers of the TDM timeslot allocator.
// ----------------------------------------------------------------------------
package tdmsa_pkg;

  // pool geometry: slot index = {stream, timeslot}
  localparam int STREAMS          = 32;
  localparam int SLOTS_PER_STREAM = 128;
  localparam int STREAM_W         = 5;
  localparam int TS_W             = 7;
  localparam int POOL_SIZE        = STREAMS * SLOTS_PER_STREAM;
  localparam int IDX_W            = $clog2(POOL_SIZE);

  // busy map storage: one 64-bit word per row
  localparam int WORD_W  = 64;
  localparam int BIT_W   = $clog2(WORD_W);
  localparam int WORDS   = POOL_SIZE / WORD_W;
  localparam int WADDR_W = $clog2(WORDS);
  localparam int CNT_W   = $clog2(WORDS + 1);
  localparam int USE_W   = 13;

  // operation codes
  localparam logic [1:0] OP_ALLOC   = 2'd0;
  localparam logic [1:0] OP_FREE    = 2'd1;
  localparam logic [1:0] OP_RESERVE = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_BUSY     = 2'd2;
  localparam logic [1:0] ST_NOT_BUSY = 2'd3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_CHECK
  } state_t;

  typedef struct packed {
    logic [1:0]          operation;
    logic [STREAM_W-1:0] stream;
    logic [TS_W-1:0]     timeslot;
  } req_t;

  typedef struct packed {
    logic [1:0]          status;
    logic [STREAM_W-1:0] granted_stream;
    logic [TS_W-1:0]     granted_timeslot;
    logic [USE_W-1:0]    slots_in_use;
  } rsp_t;

  typedef struct packed {
    logic               en;
    logic [WADDR_W-1:0] addr;
  } map_rd_t;

  typedef struct packed {
    logic               en;
    logic [WADDR_W-1:0] addr;
    logic [WORD_W-1:0]  data;
  } map_wr_t;

  typedef struct packed {
    logic             found;
    logic [BIT_W-1:0] pos;
  } ffz_t;

  // lowest clear bit of a word
  function automatic ffz_t find_free(input logic [WORD_W-1:0] w);
    ffz_t r;
    r = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (!w[i]) begin
        r.found = 1'b1;
        r.pos   = BIT_W'(i);
      end
    end
    return r;
  endfunction

endpackage

FILE: rtl/tdmsa_map.sv
// ----------------------------------------------------------------------------
// tdmsa_map
// Busy map storage: one write and one registered read port per cycle, with a
// valid bit per row so that an unwritten row reads as all free.
// ----------------------------------------------------------------------------
module tdmsa_map
  import tdmsa_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  map_rd_t           rd,
  output logic [WORD_W-1:0] rd_data,
  input  map_wr_t           wr
);

  logic [WORD_W-1:0] mem [WORDS];
  logic [WORDS-1:0]  row_valid;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (wr.en) begin
      row_valid[wr.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_data <= row_valid[rd.addr] ? mem[rd.addr] : '0;
    end
  end

endmodule

FILE: rtl/tdm_timeslot_allocator.sv
// ----------------------------------------------------------------------------
// tdm_timeslot_allocator
// Next-fit allocator for a pool of 32 x 128 TDM bus timeslots.
// ----------------------------------------------------------------------------
// The block keeps one busy bit per (stream, timeslot) slot in a 64 x 64-bit
// map and a count of busy slots, and serves one request at a time. Allocate
// scans the map from a rotating pointer, one 64-bit word per cycle through a
// single find-first-free unit, and wraps around; it takes the first free slot,
// returns its stream and timeslot and moves the pointer just past it. A full
// pool answers "no free slot" and leaves the pointer alone. Free and reserve
// act on the named slot after one map read. An allocate visits 1 to 65 map
// words (the start word is seen twice when the search wraps all the way), and
// free, reserve and the unused operation code each read one map word. The
// response sits in an output register, so a request can be taken while the
// previous response waits; a new response stalls only if the old one is still
// pending. The busy map is all free right after reset, with no clearing pass.
// ----------------------------------------------------------------------------
module tdm_timeslot_allocator
  import tdmsa_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  state_t state, state_next;

  // latched request
  logic [1:0]         op;
  logic [IDX_W-1:0]   req_idx;
  logic               in_range;

  // search context
  logic [BIT_W-1:0]   start_bit;
  logic [WADDR_W-1:0] eval_word;
  logic [CNT_W-1:0]   word_cnt;
  logic [IDX_W-1:0]   ptr, ptr_next;
  logic [USE_W-1:0]   use_count, use_next;

  // map port
  map_rd_t            map_rd;
  map_wr_t            map_wr;
  logic [WORD_W-1:0]  rd_data;

  logic               accept;
  logic               can_finish;
  logic               finish;
  rsp_t               res;
  logic [IDX_W-1:0]   req_slot;
  logic               req_fits;
  logic [WORD_W-1:0]  low_mask;
  logic [WORD_W-1:0]  word_eff;
  ffz_t               hit;
  logic [IDX_W-1:0]   hit_idx;
  logic [IDX_W:0]     hit_inc;
  logic               full;
  logic               req_bit;
  logic [WADDR_W-1:0] word_inc;

  tdmsa_map u_map (
    .clk     (clk),
    .rst     (rst),
    .rd      (map_rd),
    .rd_data (rd_data),
    .wr      (map_wr)
  );

  // handshake
  assign req_ready  = (state == S_IDLE);
  assign accept     = req_valid && req_ready;
  // a finished response may load when the output register is free or draining
  assign can_finish = !rsp_valid || rsp_ready;

  // named slot of the incoming request and its range check
  assign req_slot = {req.stream, req.timeslot};
  assign req_fits = ({1'b0, req.stream} < (STREAM_W + 1)'(STREAMS)) &&
                    ({1'b0, req.timeslot} < (TS_W + 1)'(SLOTS_PER_STREAM));

  // shared search unit: first visit of the start word hides bits before the pointer
  assign low_mask = (WORD_W'(1) << start_bit) - WORD_W'(1);
  assign word_eff = rd_data | ((word_cnt == '0) ? low_mask : '0);
  assign hit      = find_free(word_eff);
  assign hit_idx  = {eval_word, hit.pos};
  assign hit_inc  = {1'b0, hit_idx} + (IDX_W + 1)'(1);
  // start word seen again after a full lap with nothing free
  assign full     = !hit.found && (word_cnt == CNT_W'(WORDS));
  assign word_inc = (eval_word == WADDR_W'(WORDS - 1)) ? '0 : eval_word + WADDR_W'(1);

  // busy bit of the named slot
  assign req_bit = rd_data[req_idx[BIT_W-1:0]];

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = (req.operation == OP_ALLOC) ? S_SCAN : S_CHECK;
        end
      end
      S_SCAN: begin
        if ((hit.found || full) && can_finish) begin
          state_next = S_IDLE;
        end
      end
      S_CHECK: begin
        if (can_finish) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // map accesses and response
  always_comb begin
    map_rd   = '0;
    map_wr   = '0;
    finish   = 1'b0;
    res      = '0;
    ptr_next = ptr;
    use_next = use_count;
    unique case (state)
      S_IDLE: begin
        map_rd.en   = accept;
        map_rd.addr = (req.operation == OP_ALLOC) ? ptr[IDX_W-1:BIT_W]
                                                  : req_slot[IDX_W-1:BIT_W];
      end
      S_SCAN: begin
        if (hit.found) begin
          if (can_finish) begin
            finish      = 1'b1;
            map_wr.en   = 1'b1;
            map_wr.addr = eval_word;
            map_wr.data = rd_data | (WORD_W'(1) << hit.pos);
            use_next    = use_count + USE_W'(1);
            // wrap past the last slot of the pool
            ptr_next    = (hit_inc == (IDX_W + 1)'(POOL_SIZE)) ? '0 : hit_inc[IDX_W-1:0];
            res.status           = ST_OK;
            res.granted_stream   = hit_idx[IDX_W-1:TS_W];
            res.granted_timeslot = hit_idx[TS_W-1:0];
          end
        end else if (full) begin
          finish     = can_finish;
          res.status = ST_FULL;
        end else begin
          // next word of the lap
          map_rd.en   = 1'b1;
          map_rd.addr = word_inc;
        end
      end
      S_CHECK: begin
        finish = can_finish;
        case (op)
          OP_FREE: begin
            if (in_range && req_bit) begin
              map_wr.en   = can_finish;
              map_wr.addr = req_idx[IDX_W-1:BIT_W];
              map_wr.data = rd_data & ~(WORD_W'(1) << req_idx[BIT_W-1:0]);
              if (use_count != '0) begin
                use_next = use_count - USE_W'(1);
              end
              res.status = ST_OK;
            end else begin
              res.status = ST_NOT_BUSY;
            end
          end
          OP_RESERVE: begin
            if (in_range && !req_bit) begin
              map_wr.en   = can_finish;
              map_wr.addr = req_idx[IDX_W-1:BIT_W];
              map_wr.data = rd_data | (WORD_W'(1) << req_idx[BIT_W-1:0]);
              use_next    = use_count + USE_W'(1);
              res.status           = ST_OK;
              res.granted_stream   = req_idx[IDX_W-1:TS_W];
              res.granted_timeslot = req_idx[TS_W-1:0];
            end else begin
              res.status = ST_BUSY;
            end
          end
          // unused operation code: no change
          default: res.status = ST_OK;
        endcase
      end
      default: ;
    endcase
    res.slots_in_use = use_next;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ptr       <= '0;
      use_count <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (finish) begin
        ptr       <= ptr_next;
        use_count <= use_next;
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // request and search context
  always_ff @(posedge clk) begin
    if (accept) begin
      op        <= req.operation;
      req_idx   <= req_slot;
      in_range  <= req_fits;
      start_bit <= ptr[BIT_W-1:0];
      eval_word <= map_rd.addr;
      word_cnt  <= '0;
    end else if (map_rd.en) begin
      eval_word <= word_inc;
      word_cnt  <= word_cnt + CNT_W'(1);
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (finish) begin
      rsp <= res;
    end
  end

`ifndef SYNTHESIS
  // the count of busy slots never passes the pool size
  a_use_bound: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.slots_in_use <= USE_W'(POOL_SIZE)))
    else $error("slots_in_use above pool size");

  // a failed request never names a slot
  a_no_grant: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (rsp.status != ST_OK)) |->
      ((rsp.granted_stream == '0) && (rsp.granted_timeslot == '0)))
    else $error("grant fields set on failed request");

  // an accepted request always leaves idle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state != S_IDLE))
    else $error("sequencer stayed idle after accept");

  // the lap counter never runs past one full wrap
  a_lap_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (word_cnt <= CNT_W'(WORDS)))
    else $error("search ran past one lap");
`endif

endmodule
